// ===== rtl/core/wmsc_pkg.sv =====
`default_nettype none

package wmsc_pkg;

    // Field and register widths
    localparam int TimeW  = 32;
    localparam int SpeedW = 10;
    localparam int LevelW = 12;
    localparam int DriveW = 11;
    localparam int PosW   = 32;
    localparam int CfgIdxW = 3;

    // Ramp divider: quotient never exceeds run_speed, so it has SpeedW bits
    localparam int QuotW = SpeedW;
    localparam int RemW  = SpeedW + TimeW;
    localparam int CntW  = $clog2(QuotW);

    // Operation codes
    localparam logic [1:0] OpTick  = 2'd0;
    localparam logic [1:0] OpStart = 2'd1;
    localparam logic [1:0] OpStop  = 2'd2;

    // Motion phases as reported on the result
    localparam logic [1:0] PhIdle = 2'd0;
    localparam logic [1:0] PhRamp = 2'd1;
    localparam logic [1:0] PhMove = 2'd2;
    localparam logic [1:0] PhDown = 2'd3;

    // Error codes
    localparam logic [1:0] ErrNone   = 2'd0;
    localparam logic [1:0] ErrMotor  = 2'd1;
    localparam logic [1:0] ErrSensor = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgRunSpeed  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgRampTime  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgRewind    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgMaxStep   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgSlowStep  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgCooldown  = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgLowTh     = 3'd6;
    localparam logic [CfgIdxW-1:0] CfgHighTh    = 3'd7;

    // Rewind pulse magnitude
    localparam logic signed [DriveW-1:0] RewindDrive = 11'sd512;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_step;
        logic out_write;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/wmsc_ifs.sv =====
`default_nettype none

interface wmsc_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [wmsc_pkg::TimeW-1:0]      timestamp;
    logic                            run_forward;
    logic                            sample_valid;
    logic                            sample_error;
    logic [wmsc_pkg::LevelW-1:0]     sample_level;
    logic                            driver_fault;

    modport source (
        output valid, operation, timestamp, run_forward, sample_valid,
               sample_error, sample_level, driver_fault,
        input  ready
    );
    modport sink (
        input  valid, operation, timestamp, run_forward, sample_valid,
               sample_error, sample_level, driver_fault,
        output ready
    );
endinterface

interface wmsc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [wmsc_pkg::DriveW-1:0]  drive_level;
    logic                                driver_on;
    logic                                sensor_on;
    logic                                position_valid;
    logic signed [wmsc_pkg::PosW-1:0]    wheel_position;
    logic [1:0]                          error_code;
    logic [1:0]                          phase;

    modport source (
        output valid, drive_level, driver_on, sensor_on, position_valid,
               wheel_position, error_code, phase,
        input  ready
    );
    modport sink (
        input  valid, drive_level, driver_on, sensor_on, position_valid,
               wheel_position, error_code, phase,
        output ready
    );
endinterface

interface wmsc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wmsc_pkg::CfgIdxW-1:0]      index;
    logic [wmsc_pkg::TimeW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wmsc_ctrl.sv =====
`default_nettype none

module wmsc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire wmsc_pkg::t_sts i_sts,
    output wmsc_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.div_needed ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_eval_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |=> (r_state == ST_MUL || r_state == ST_DONE))
        else $error("eval not followed by multiply or result write");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wmsc_dp.sv =====
`default_nettype none

module wmsc_dp (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    wmsc_in_if.sink          i_item,
    wmsc_out_if.source       o_result,
    wmsc_cfg_if.sink         i_cfg,
    input  wire wmsc_pkg::t_cmd i_cmd,
    output wmsc_pkg::t_sts   o_sts
);

    localparam int TimeW  = wmsc_pkg::TimeW;
    localparam int SpeedW = wmsc_pkg::SpeedW;
    localparam int LevelW = wmsc_pkg::LevelW;
    localparam int DriveW = wmsc_pkg::DriveW;
    localparam int PosW   = wmsc_pkg::PosW;
    localparam int QuotW  = wmsc_pkg::QuotW;
    localparam int RemW   = wmsc_pkg::RemW;
    localparam int CntW   = wmsc_pkg::CntW;

    // Configuration
    logic [SpeedW-1:0] r_run_speed;
    logic [TimeW-1:0]  r_ramp_time, r_rewind_time, r_max_step, r_slow_step, r_cooldown;
    logic [LevelW-1:0] r_low_th, r_high_th;

    // Captured request
    logic [1:0]        r_op;
    logic [TimeW-1:0]  r_t;
    logic              r_fwd, r_sv, r_se, r_fault;
    logic [LevelW-1:0] r_lvl;

    // Controller state
    logic [1:0]               r_phase, n_phase;
    logic                     r_dir_neg, n_dir_neg;
    logic [PosW-1:0]          r_pos, n_pos;
    logic [TimeW-1:0]         r_ps_time, n_ps_time;
    logic [TimeW-1:0]         r_ls_time, n_ls_time;
    logic                     r_ls_valid, n_ls_valid;
    logic                     r_mark, n_mark;
    logic signed [DriveW-1:0] r_drive, n_drive;
    logic                     r_drv_en, n_drv_en;
    logic                     r_sen_en, n_sen_en;

    // Per-request results and ramp divider
    logic             r_new_pos, n_new_pos;
    logic [1:0]       r_err, n_err;
    logic [TimeW-1:0] r_ramp_d;
    logic [RemW-1:0]  r_rem, n_rem;
    logic [RemW-1:0]  r_dsh, n_dsh;
    logic [QuotW-1:0] r_q, n_q;
    logic [CntW-1:0]  r_cnt, n_cnt;

    // Output register
    logic r_out_valid;

    // Evaluation terms
    logic             w_sample_ok, w_step;
    logic [TimeW-1:0] w_ls_eff, w_el_ps, w_el_ls;
    logic             w_ls_valid_eff, w_stalled;
    logic [RemW:0]    w_trial;
    logic             w_qbit;
    logic signed [DriveW-1:0] w_rs_drive, w_q_drive;

    assign w_sample_ok    = (r_op == wmsc_pkg::OpTick) && r_sv && !r_se;
    assign w_step         = w_sample_ok && !r_mark && (r_lvl > r_high_th);
    assign w_ls_eff       = w_step ? r_t : r_ls_time;
    assign w_ls_valid_eff = w_step || r_ls_valid;
    assign w_el_ps        = r_t - r_ps_time;
    assign w_el_ls        = r_t - w_ls_eff;
    assign w_stalled      = r_fault || (w_ls_valid_eff && (w_el_ls >= r_max_step));

    assign w_trial    = {1'b0, r_rem} - {1'b0, r_dsh};
    assign w_qbit     = !w_trial[RemW];
    assign n_q        = {r_q[QuotW-2:0], w_qbit};
    assign w_rs_drive = $signed({1'b0, r_run_speed});
    assign w_q_drive  = $signed({1'b0, n_q});

    assign o_sts.div_needed = (r_op == wmsc_pkg::OpTick) && (r_phase == wmsc_pkg::PhRamp)
                              && !w_stalled && (w_el_ps < r_ramp_time);
    assign o_sts.div_last   = (r_cnt == '0);
    assign o_sts.out_free   = !r_out_valid || o_result.ready;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_phase    = r_phase;
        n_dir_neg  = r_dir_neg;
        n_pos      = r_pos;
        n_ps_time  = r_ps_time;
        n_ls_time  = r_ls_time;
        n_ls_valid = r_ls_valid;
        n_mark     = r_mark;
        n_drive    = r_drive;
        n_drv_en   = r_drv_en;
        n_sen_en   = r_sen_en;
        n_new_pos  = r_new_pos;
        n_err      = r_err;
        n_rem      = r_rem;
        n_dsh      = r_dsh;
        n_cnt      = r_cnt;

        if (i_cmd.eval) begin
            n_new_pos = w_step;
            n_err     = wmsc_pkg::ErrNone;
            // hysteresis on the IR mark
            if (w_sample_ok) begin
                if (r_mark && (r_lvl < r_low_th)) begin
                    n_mark = 1'b0;
                end else if (w_step) begin
                    n_mark     = 1'b1;
                    n_pos      = r_dir_neg ? r_pos - 1'b1 : r_pos + 1'b1;
                    n_ls_time  = r_t;
                    n_ls_valid = 1'b1;
                end
            end
            unique case (r_op)
                wmsc_pkg::OpStart: begin
                    if (r_phase == wmsc_pkg::PhIdle) begin
                        n_dir_neg  = !r_fwd;
                        n_phase    = wmsc_pkg::PhRamp;
                        n_ps_time  = r_t;
                        n_ls_time  = r_t;
                        n_ls_valid = 1'b1;
                        n_drv_en   = 1'b1;
                        n_sen_en   = 1'b1;
                        n_drive    = '0;
                    end
                end
                wmsc_pkg::OpStop: begin
                    if (r_phase == wmsc_pkg::PhRamp) begin
                        n_phase    = wmsc_pkg::PhIdle;
                        n_drv_en   = 1'b0;
                        n_ps_time  = r_t;
                        n_ls_valid = 1'b0;
                    end else if (r_phase == wmsc_pkg::PhMove) begin
                        n_phase    = wmsc_pkg::PhDown;
                        n_ps_time  = r_t;
                        n_ls_valid = 1'b0;
                        n_drv_en   = 1'b1;
                        n_sen_en   = 1'b1;
                        n_drive    = r_dir_neg ? wmsc_pkg::RewindDrive
                                               : -wmsc_pkg::RewindDrive;
                    end
                end
                wmsc_pkg::OpTick: begin
                    unique case (r_phase)
                        wmsc_pkg::PhIdle: begin
                            if (w_el_ps >= r_cooldown) begin
                                n_sen_en = 1'b0;
                            end
                        end
                        wmsc_pkg::PhRamp: begin
                            if (w_stalled) begin
                                n_err      = wmsc_pkg::ErrMotor;
                                n_phase    = wmsc_pkg::PhIdle;
                                n_drv_en   = 1'b0;
                                n_ps_time  = r_t;
                                n_ls_valid = 1'b0;
                            end else if (w_el_ps >= r_ramp_time) begin
                                n_ps_time = r_t;
                                n_phase   = wmsc_pkg::PhMove;
                                n_drv_en  = 1'b1;
                                n_sen_en  = 1'b1;
                                n_drive   = r_dir_neg ? -w_rs_drive : w_rs_drive;
                            end
                        end
                        wmsc_pkg::PhMove: begin
                            if (w_stalled) begin
                                n_err      = wmsc_pkg::ErrMotor;
                                n_phase    = wmsc_pkg::PhIdle;
                                n_drv_en   = 1'b0;
                                n_ps_time  = r_t;
                                n_ls_valid = 1'b0;
                            end else if (w_ls_valid_eff && (w_el_ls >= r_slow_step)) begin
                                n_err = wmsc_pkg::ErrSensor;
                            end
                        end
                        wmsc_pkg::PhDown: begin
                            if (w_el_ps >= r_rewind_time) begin
                                n_phase    = wmsc_pkg::PhIdle;
                                n_drv_en   = 1'b0;
                                n_ps_time  = r_t;
                                n_ls_valid = 1'b0;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (i_cmd.mul) begin
            n_rem = RemW'(r_run_speed) * RemW'(r_ramp_d);
            n_dsh = RemW'(r_ramp_time) << (QuotW - 1);
            n_cnt = CntW'(QuotW - 1);
        end

        // restoring divide, one quotient bit per cycle
        if (i_cmd.div_step) begin
            n_rem = w_qbit ? w_trial[RemW-1:0] : r_rem;
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_drive = r_dir_neg ? -w_q_drive : w_q_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_speed   <= SpeedW'(512);
            r_ramp_time   <= TimeW'(100000);
            r_rewind_time <= TimeW'(50000);
            r_max_step    <= TimeW'(1000000);
            r_slow_step   <= TimeW'(500000);
            r_cooldown    <= TimeW'(1000000);
            r_low_th      <= LevelW'(1000);
            r_high_th     <= LevelW'(3000);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                wmsc_pkg::CfgRunSpeed: r_run_speed   <= i_cfg.data[SpeedW-1:0];
                wmsc_pkg::CfgRampTime: r_ramp_time   <= i_cfg.data;
                wmsc_pkg::CfgRewind:   r_rewind_time <= i_cfg.data;
                wmsc_pkg::CfgMaxStep:  r_max_step    <= i_cfg.data;
                wmsc_pkg::CfgSlowStep: r_slow_step   <= i_cfg.data;
                wmsc_pkg::CfgCooldown: r_cooldown    <= i_cfg.data;
                wmsc_pkg::CfgLowTh:    r_low_th      <= i_cfg.data[LevelW-1:0];
                wmsc_pkg::CfgHighTh:   r_high_th     <= i_cfg.data[LevelW-1:0];
                default:               r_low_th      <= r_low_th;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= wmsc_pkg::PhIdle;
            r_dir_neg  <= 1'b0;
            r_pos      <= '0;
            r_ps_time  <= '0;
            r_ls_time  <= '0;
            r_ls_valid <= 1'b0;
            r_mark     <= 1'b0;
            r_drive    <= '0;
            r_drv_en   <= 1'b0;
            r_sen_en   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_dir_neg  <= n_dir_neg;
            r_pos      <= n_pos;
            r_ps_time  <= n_ps_time;
            r_ls_time  <= n_ls_time;
            r_ls_valid <= n_ls_valid;
            r_mark     <= n_mark;
            r_drive    <= n_drive;
            r_drv_en   <= n_drv_en;
            r_sen_en   <= n_sen_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_item.operation;
            r_t     <= i_item.timestamp;
            r_fwd   <= i_item.run_forward;
            r_sv    <= i_item.sample_valid;
            r_se    <= i_item.sample_error;
            r_lvl   <= i_item.sample_level;
            r_fault <= i_item.driver_fault;
        end
        if (i_cmd.eval) begin
            r_ramp_d <= w_el_ps;
        end
        r_new_pos <= n_new_pos;
        r_err     <= n_err;
        r_rem     <= n_rem;
        r_dsh     <= n_dsh;
        r_cnt     <= n_cnt;
        if (i_cmd.div_step) begin
            r_q <= n_q;
        end else if (i_cmd.mul) begin
            r_q <= '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            o_result.drive_level    <= r_drive;
            o_result.driver_on      <= r_drv_en;
            o_result.sensor_on      <= r_sen_en;
            o_result.position_valid <= r_new_pos && (r_err == wmsc_pkg::ErrNone);
            o_result.wheel_position <= $signed(r_pos);
            o_result.error_code     <= r_err;
            o_result.phase          <= r_phase;
        end
    end

    assign o_result.valid = r_out_valid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_write |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten before it was taken");
    a_idle_drv_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wmsc_pkg::PhIdle) |-> !r_drv_en)
        else $error("driver enabled while idle");
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && o_sts.div_last) |=> (r_q <= r_run_speed))
        else $error("ramp value above run speed");
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_drive[DriveW-1] && (r_drive[DriveW-2:0] == '0)))
        else $error("drive level out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wheel_motor_step_controller.sv =====
`default_nettype none

// Dispenser wheel motor step controller. Takes one request at a time (tick,
// start or stop, with a microsecond timestamp) and returns one result per
// request: held drive level, driver and sensor enables, step position and
// error code, and the motion phase. A request passes through accept, evaluate
// and result write; a tick in the ramp-up phase that does not end the ramp
// also passes through a multiply and a divide step, since the linear ramp
// value run_speed * elapsed / ramp_up_time comes from a restoring divider
// that resolves one of its 10 quotient bits per cycle. The result sits in
// an output register, so the next request is accepted while an earlier result
// waits; a result that is not taken holds the following one in its last cycle.
// Configuration writes are always accepted and must only be issued while no
// request is in flight. Time differences wrap modulo 2^32.

module wheel_motor_step_controller (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wmsc_in_if.sink      i_item,
    wmsc_out_if.source   o_result,
    wmsc_cfg_if.sink     i_cfg
);

    // Command and status between sequencer and datapath
    wmsc_pkg::t_cmd w_cmd;
    wmsc_pkg::t_sts w_sts;
    logic           w_in_ready;

    // Request handshake is owned by the sequencer: ready only between requests
    assign i_item.ready = w_in_ready;

    // Sequencer: accept, evaluate, optional multiply and divide, write result
    wmsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: config registers, phase state, step tracking, ramp divider,
    // output register
    wmsc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts)
    );

endmodule

`default_nettype wire
